### sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked on every edge out of reset
`define UPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define UPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define UPQ_ASSERT(label, prop, msg)
`define UPQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### sv/upq_pkg.sv
package upq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 7;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

### sv/unsorted_array_priority_queue_core.sv
// channel    dir  tdata (low bit up)                                  tuser
// s_axis     in   item_value[31:0], item_priority[63:32]              action[1:0]
// m_axis     out  out_value[31:0], out_priority[63:32],               status[1:0]
//                 occupancy[70:64], zero fill [71]
//
// enqueue, no-op and any request on an empty queue answer in the cycle after the beat
// dequeue and peek scan the queue: one memory read per held entry through the
// registered read port, then the finish state answers and (dequeue) writes back
// one item is in flight at a time; s_axis is ready when idle and the result
// register is free or being emptied
// i_rst_n is synchronous and active low; it empties the queue, memory is not cleared
// a stalled m_axis holds its beat; the queue takes no new item until it moves on
`include "assert_macros.svh"

module unsorted_array_priority_queue_core #(
    parameter int CAPACITY = upq_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // item_value, item_priority
    input  logic [1:0]  i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // out_value, out_priority, occupancy, zero fill
    output logic [1:0]  o_m_axis_tuser    // status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = upq_pkg::DATA_W;
    localparam int OW = upq_pkg::OCC_W;

    // entries are kept packed in slots 0 .. count-1: a dequeue fills its hole
    // with the last entry, so no per-slot valid bit is needed
    logic [2*DW-1:0] r_mem [CAPACITY];

    upq_pkg::t_state  r_state, n_state;
    upq_pkg::t_action r_op;
    upq_pkg::t_action in_action;

    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr;       // next scan read address
    logic            r_rvalid;    // read data present this cycle
    logic [AW-1:0]   r_ridx;      // slot of the read data
    logic [2*DW-1:0] r_rdata;
    logic [AW-1:0]   r_best_idx;
    logic [2*DW-1:0] r_best;      // {priority, value} of the best so far
    logic [2*DW-1:0] r_last;      // entry in the highest occupied slot

    logic            r_m_valid;
    upq_pkg::t_status r_m_status;
    logic [DW-1:0]   r_m_value;
    logic [DW-1:0]   r_m_prio;
    logic [OW-1:0]   r_m_occ;

    logic            s_accept;
    logic            full;
    logic            empty;
    logic            fast_op;     // answered straight from the beat
    logic            scan_start;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [2*DW-1:0] wr_data;
    logic [CW-1:0]   count_m1;
    logic [AW-1:0]   last_idx;
    logic            last_beat;
    logic            take;
    logic            load_fast;
    logic            load_scan;
    logic [CW+OW-1:0] occ_ext;

    assign in_action = upq_pkg::t_action'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == upq_pkg::S_IDLE) && (!r_m_valid || i_m_axis_tready);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign full  = (r_count >= CW'(CAPACITY));
    assign empty = (r_count == '0);

    assign scan_start = s_accept && !empty &&
                        ((in_action == upq_pkg::ACT_DEQ) || (in_action == upq_pkg::ACT_PEEK));
    assign fast_op    = s_accept && !scan_start;

    assign count_m1  = r_count - 1'b1;
    assign last_idx  = count_m1[AW-1:0];
    assign last_beat = r_rvalid && (r_ridx == last_idx);

    // best key: lowest signed priority, then highest signed value
    always_comb begin
        take = (r_ridx == '0);
        if ($signed(r_rdata[2*DW-1:DW]) < $signed(r_best[2*DW-1:DW])) begin
            take = 1'b1;
        end else if ((r_rdata[2*DW-1:DW] == r_best[2*DW-1:DW]) &&
                     ($signed(r_rdata[DW-1:0]) > $signed(r_best[DW-1:0]))) begin
            take = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            upq_pkg::S_IDLE: begin
                if (scan_start) begin
                    n_state = upq_pkg::S_SCAN;
                end
            end
            upq_pkg::S_SCAN: begin
                if (last_beat) begin
                    n_state = upq_pkg::S_FINISH;
                end
            end
            upq_pkg::S_FINISH: begin
                n_state = upq_pkg::S_IDLE;
            end
            default: begin
                n_state = upq_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs: memory ports, count update, result loads
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = r_ptr[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = {i_s_axis_tdata[2*DW-1:DW], i_s_axis_tdata[DW-1:0]};
        n_count   = r_count;
        load_fast = 1'b0;
        load_scan = 1'b0;
        case (r_state)
            upq_pkg::S_IDLE: begin
                load_fast = fast_op;
                if (s_accept && (in_action == upq_pkg::ACT_ENQ) && !full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            upq_pkg::S_SCAN: begin
                rd_en = (r_ptr != r_count);
            end
            upq_pkg::S_FINISH: begin
                load_scan = 1'b1;
                if (r_op == upq_pkg::ACT_DEQ) begin
                    wr_en   = 1'b1;
                    wr_addr = r_best_idx;
                    wr_data = r_last;
                    n_count = count_m1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // occupancy is the count folded to seven bits
    assign occ_ext = {{OW{1'b0}}, n_count};

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= upq_pkg::S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_rvalid  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rvalid <= rd_en;
            if (scan_start) begin
                r_ptr <= '0;
            end else if (rd_en) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (load_fast || load_scan) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge i_clk) begin
        if (scan_start) begin
            r_op <= in_action;
        end
        if (rd_en) begin
            r_ridx <= r_ptr[AW-1:0];
        end
        if (r_rvalid && take) begin
            r_best     <= r_rdata;
            r_best_idx <= r_ridx;
        end
        if (last_beat) begin
            r_last <= r_rdata;
        end
        if (load_fast) begin
            r_m_value <= '0;
            r_m_prio  <= '0;
            r_m_occ   <= occ_ext[OW-1:0];
            if ((in_action == upq_pkg::ACT_ENQ) && full) begin
                r_m_status <= upq_pkg::ST_FULL;
            end else if ((in_action == upq_pkg::ACT_DEQ) || (in_action == upq_pkg::ACT_PEEK)) begin
                r_m_status <= upq_pkg::ST_EMPTY;
            end else begin
                r_m_status <= upq_pkg::ST_OK;
            end
        end else if (load_scan) begin
            r_m_value  <= r_best[DW-1:0];
            r_m_prio   <= r_best[2*DW-1:DW];
            r_m_occ    <= occ_ext[OW-1:0];
            r_m_status <= upq_pkg::ST_OK;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_occ, r_m_prio, r_m_value};
    assign o_m_axis_tuser  = r_m_status;

    `UPQ_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count beyond capacity")
    `UPQ_ASSERT(a_ptr_bound, (r_state == upq_pkg::S_SCAN) |-> (r_ptr <= r_count), "scan pointer past count")
    `UPQ_ASSERT(a_rvalid_scan, r_rvalid |-> (r_state == upq_pkg::S_SCAN), "read data outside scan")
    `UPQ_ASSERT(a_best_held, (r_state == upq_pkg::S_FINISH) |-> (CW'(r_best_idx) < r_count), "best slot not occupied")
    `UPQ_ASSERT(a_deq_count, ((r_state == upq_pkg::S_FINISH) && (r_op == upq_pkg::ACT_DEQ)) |=> (r_count == $past(count_m1)), "dequeue did not drop count")

endmodule
